// File: hdl/rsid_pkg.sv
package rsid_pkg;

  localparam int unsigned CountWidth   = 6;
  localparam int unsigned MaxBytesDflt = 32;

  localparam logic [7:0] OpOperandSize = 8'h66;
  localparam logic [7:0] OpAddrSize    = 8'h67;
  localparam logic [7:0] OpRexW        = 8'h48;
  localparam logic [7:0] OpRepne       = 8'hF2;
  localparam logic [7:0] OpRep         = 8'hF3;
  localparam logic [7:0] OpMovsB       = 8'hA4;
  localparam logic [7:0] OpMovsW       = 8'hA5;
  localparam logic [7:0] OpCmpsB       = 8'hA6;
  localparam logic [7:0] OpCmpsW       = 8'hA7;
  localparam logic [7:0] OpStosB       = 8'hAA;
  localparam logic [7:0] OpStosW       = 8'hAB;
  localparam logic [7:0] OpLodsB       = 8'hAC;
  localparam logic [7:0] OpLodsW       = 8'hAD;
  localparam logic [7:0] OpScasB       = 8'hAE;
  localparam logic [7:0] OpScasW       = 8'hAF;

  localparam logic [1:0] SizeByte  = 2'd0;
  localparam logic [1:0] SizeWord  = 2'd1;
  localparam logic [1:0] SizeDword = 2'd2;
  localparam logic [1:0] SizeQword = 2'd3;

  typedef struct packed {
    logic                  accepted;
    logic [CountWidth-1:0] insn_length;
    logic [1:0]            operand_size_code;
    logic                  writes_flags;
    logic                  uses_source_index;
    logic                  repeat_not_equal;
    logic                  address_override;
  } rsid_result_t;

endpackage

// File: hdl/rsid_decode.sv
module rsid_decode #(
  parameter int unsigned MaxBytes = rsid_pkg::MaxBytesDflt
) (
  input  logic                  clk_i,
  input  logic                  rst_ni,
  input  logic                  fire_i,
  input  logic [7:0]            code_byte_i,
  input  logic                  end_of_buffer_i,
  input  logic                  mode_64bit_i,
  output logic                  res_valid_o,
  output rsid_pkg::rsid_result_t res_o
);
  import rsid_pkg::*;

  localparam logic [CountWidth-1:0] MaxCount = CountWidth'(MaxBytes);

  logic                  opsz_q, opsz_d;
  logic                  adsz_q, adsz_d;
  logic                  rep_q, rep_d;
  logic                  repne_q, repne_d;
  logic                  rexw_q, rexw_d;
  logic                  skip_q, skip_d;
  logic [CountWidth-1:0] count_q, count_d;

  logic [CountWidth-1:0] count_inc;
  logic                  is_prefix;
  logic                  is_string;
  logic                  flags_mod;
  logic                  uses_si;
  logic                  reject;
  logic [1:0]            size_code;

  assign count_inc = count_q + CountWidth'(1);

  always_comb begin
    is_prefix = 1'b0;
    is_string = 1'b0;
    flags_mod = 1'b0;
    uses_si   = 1'b0;
    unique case (code_byte_i)
      OpOperandSize, OpAddrSize, OpRepne, OpRep: is_prefix = 1'b1;
      OpRexW: is_prefix = mode_64bit_i;
      OpMovsB, OpMovsW: begin
        is_string = 1'b1;
        uses_si   = 1'b1;
      end
      OpStosB, OpStosW, OpLodsB, OpLodsW: is_string = 1'b1;
      OpCmpsB, OpCmpsW: begin
        is_string = 1'b1;
        flags_mod = 1'b1;
        uses_si   = 1'b1;
      end
      OpScasB, OpScasW: begin
        is_string = 1'b1;
        flags_mod = 1'b1;
      end
      default: ;
    endcase
  end

  always_comb begin
    if (!code_byte_i[0]) begin
      size_code = SizeByte;
    end else if (rexw_q) begin
      size_code = SizeQword;
    end else if (opsz_q) begin
      size_code = SizeWord;
    end else begin
      size_code = SizeDword;
    end
  end

  always_comb begin
    opsz_d      = opsz_q;
    adsz_d      = adsz_q;
    rep_d       = rep_q;
    repne_d     = repne_q;
    rexw_d      = rexw_q;
    skip_d      = skip_q;
    count_d     = count_q;
    res_valid_o = 1'b0;
    res_o       = '0;
    reject      = 1'b0;
    if (fire_i) begin
      if (skip_q) begin
        if (end_of_buffer_i) begin
          skip_d = 1'b0;
        end
      end else begin
        if (is_prefix) begin
          reject = end_of_buffer_i || (count_inc >= MaxCount);
        end else if (is_string) begin
          reject = !rep_q;
        end else begin
          reject = 1'b1;
        end
        if (is_prefix && !reject) begin
          count_d = count_inc;
          if (code_byte_i == OpOperandSize) opsz_d = 1'b1;
          if (code_byte_i == OpAddrSize) adsz_d = 1'b1;
          if (code_byte_i == OpRexW) rexw_d = 1'b1;
          if (code_byte_i == OpRepne) repne_d = 1'b1;
          if (code_byte_i == OpRepne || code_byte_i == OpRep) rep_d = 1'b1;
        end else begin
          res_valid_o = 1'b1;
          if (!reject) begin
            res_o.accepted          = 1'b1;
            res_o.insn_length       = count_inc;
            res_o.operand_size_code = size_code;
            res_o.writes_flags      = flags_mod;
            res_o.uses_source_index = uses_si;
            res_o.repeat_not_equal  = repne_q;
            res_o.address_override  = adsz_q;
          end
          opsz_d  = 1'b0;
          adsz_d  = 1'b0;
          rep_d   = 1'b0;
          repne_d = 1'b0;
          rexw_d  = 1'b0;
          count_d = '0;
          skip_d  = !end_of_buffer_i;
        end
      end
      if (skip_q && end_of_buffer_i) begin
        opsz_d  = 1'b0;
        adsz_d  = 1'b0;
        rep_d   = 1'b0;
        repne_d = 1'b0;
        rexw_d  = 1'b0;
        count_d = '0;
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      opsz_q  <= 1'b0;
      adsz_q  <= 1'b0;
      rep_q   <= 1'b0;
      repne_q <= 1'b0;
      rexw_q  <= 1'b0;
      skip_q  <= 1'b0;
      count_q <= '0;
    end else begin
      opsz_q  <= opsz_d;
      adsz_q  <= adsz_d;
      rep_q   <= rep_d;
      repne_q <= repne_d;
      rexw_q  <= rexw_d;
      skip_q  <= skip_d;
      count_q <= count_d;
    end
  end

  a_accept_len: assert property (@(posedge clk_i) disable iff (!rst_ni)
    res_valid_o && res_o.accepted |-> res_o.insn_length != '0)
    else $error("accepted result with zero length");

  a_reject_zero: assert property (@(posedge clk_i) disable iff (!rst_ni)
    res_valid_o && !res_o.accepted |-> res_o == '0)
    else $error("rejected result carries nonzero fields");

  a_skip_silent: assert property (@(posedge clk_i) disable iff (!rst_ni)
    fire_i && skip_q |-> !res_valid_o)
    else $error("result produced while skipping");

  a_result_clears: assert property (@(posedge clk_i) disable iff (!rst_ni)
    res_valid_o |=> count_q == '0 && !rep_q)
    else $error("decoder state not cleared after result");

endmodule

// File: hdl/rep_string_instruction_decoder.sv
// REP string instruction decoder.
// Input channel: one code byte per transaction (code_byte_i, end_of_buffer_i),
// handshaked by in_valid_i / in_stall_o. Output channel: one result per
// transaction on accepted_o .. address_override_o, handshaked by out_valid_o /
// out_stall_i. Prefix bytes and bytes skipped after a result produce no
// output; a string opcode, an unknown byte, a missing opcode at end of buffer
// or a prefix reaching MaxBytes produces exactly one result.
// A byte passes from the input register through the combinational decode into
// the result register that drives out_valid_o. Throughput: one byte per cycle
// while no result is held by out_stall_i, set by that register chain.
// The input register keeps taking bytes while a result waits, as long as the
// decode stage can drain; if the result register is held by out_stall_i and
// the input register is full, in_stall_o is raised.
// Reset clears all prefix flags, the byte count, the skip flag and both
// valid flags, and sets mode_64bit to 1. mode_64bit_we_i writes the mode bit.
module rep_string_instruction_decoder #(
  parameter int unsigned MaxBytes = rsid_pkg::MaxBytesDflt
) (
  input  logic       clk_i,
  input  logic       rst_ni,
  input  logic       mode_64bit_we_i,
  input  logic       mode_64bit_i,
  input  logic       in_valid_i,
  output logic       in_stall_o,
  input  logic [7:0] code_byte_i,
  input  logic       end_of_buffer_i,
  output logic       out_valid_o,
  input  logic       out_stall_i,
  output logic       accepted_o,
  output logic [5:0] insn_length_o,
  output logic [1:0] operand_size_code_o,
  output logic       writes_flags_o,
  output logic       uses_source_index_o,
  output logic       repeat_not_equal_o,
  output logic       address_override_o
);
  import rsid_pkg::*;

  logic         mode_q;
  logic         in_valid_q;
  logic [7:0]   byte_q;
  logic         eob_q;
  logic         out_valid_q;
  rsid_result_t out_q;
  logic         consume;
  logic         in_take;
  logic         res_valid;
  rsid_result_t res;

  assign consume    = in_valid_q && (!out_valid_q || !out_stall_i);
  assign in_stall_o = in_valid_q && !consume;
  assign in_take    = in_valid_i && !in_stall_o;

  rsid_decode #(
    .MaxBytes(MaxBytes)
  ) u_decode (
    .clk_i          (clk_i),
    .rst_ni         (rst_ni),
    .fire_i         (consume),
    .code_byte_i    (byte_q),
    .end_of_buffer_i(eob_q),
    .mode_64bit_i   (mode_q),
    .res_valid_o    (res_valid),
    .res_o          (res)
  );

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      mode_q      <= 1'b1;
      in_valid_q  <= 1'b0;
      out_valid_q <= 1'b0;
    end else begin
      if (mode_64bit_we_i) begin
        mode_q <= mode_64bit_i;
      end
      if (in_take) begin
        in_valid_q <= 1'b1;
      end else if (consume) begin
        in_valid_q <= 1'b0;
      end
      if (consume && res_valid) begin
        out_valid_q <= 1'b1;
      end else if (!out_stall_i) begin
        out_valid_q <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (in_take) begin
      byte_q <= code_byte_i;
      eob_q  <= end_of_buffer_i;
    end
    if (consume && res_valid) begin
      out_q <= res;
    end
  end

  assign out_valid_o         = out_valid_q;
  assign accepted_o          = out_q.accepted;
  assign insn_length_o       = out_q.insn_length;
  assign operand_size_code_o = out_q.operand_size_code;
  assign writes_flags_o      = out_q.writes_flags;
  assign uses_source_index_o = out_q.uses_source_index;
  assign repeat_not_equal_o  = out_q.repeat_not_equal;
  assign address_override_o  = out_q.address_override;

  a_no_overwrite: assert property (@(posedge clk_i) disable iff (!rst_ni)
    consume && res_valid |-> !(out_valid_q && out_stall_i))
    else $error("result register overwritten while stalled");

  a_hold_input: assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_valid_q && !consume |=> in_valid_q && $stable(byte_q))
    else $error("pending input byte lost");

  a_stall_full: assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_stall_o |-> in_valid_q && out_valid_q && out_stall_i)
    else $error("input stalled without a full pipeline");

endmodule

// File: bench/rep_string_decode_checker.sv
module rep_string_decode_checker (
  input  logic       clk_i,
  input  logic       rst_ni,
  input  logic       mode_64bit_we_i,
  input  logic       mode_64bit_i,
  input  logic       in_valid_i,
  input  logic       in_stall_i,
  input  logic [7:0] code_byte_i,
  input  logic       end_of_buffer_i,
  input  logic       out_valid_i,
  input  logic       out_stall_i,
  input  logic       accepted_i,
  input  logic [5:0] insn_length_i,
  input  logic [1:0] operand_size_code_i,
  input  logic       writes_flags_i,
  input  logic       uses_source_index_i,
  input  logic       repeat_not_equal_i,
  input  logic       address_override_i,
  output int         mismatch_count_o,
  output int         pending_o,
  output int         decoded_bytes_o,
  output int         results_checked_o,
  output int         insns_accepted_o
);
  timeunit 1ns;
  timeprecision 1ps;
  import rsid_pkg::*;

  rsid_result_t          decoded_insns[$];
  logic                  long_mode;
  logic                  opsize_seen;
  logic                  addrsize_seen;
  logic                  rep_seen;
  logic                  repne_seen;
  logic                  rexw_seen;
  logic [CountWidth-1:0] insn_bytes;
  logic                  skipping;

  task automatic clear_insn_state();
    opsize_seen   = 1'b0;
    addrsize_seen = 1'b0;
    rep_seen      = 1'b0;
    repne_seen    = 1'b0;
    rexw_seen     = 1'b0;
    insn_bytes    = '0;
    skipping      = 1'b0;
  endtask

  task automatic decode_code_byte(input logic [7:0] code, input logic last);
    rsid_result_t res;
    logic         is_prefix;
    logic         bad_byte;
    res       = '0;
    is_prefix = 1'b0;
    bad_byte  = 1'b0;
    if (skipping) begin
      if (last) begin
        clear_insn_state();
      end
      return;
    end
    decoded_bytes_o++;
    insn_bytes = insn_bytes + CountWidth'(1);
    case (code)
      OpOperandSize: begin
        opsize_seen = 1'b1;
        is_prefix   = 1'b1;
      end
      OpAddrSize: begin
        addrsize_seen = 1'b1;
        is_prefix     = 1'b1;
      end
      OpRexW: begin
        if (long_mode) begin
          rexw_seen = 1'b1;
          is_prefix = 1'b1;
        end else begin
          bad_byte = 1'b1;
        end
      end
      OpRepne: begin
        repne_seen = 1'b1;
        rep_seen   = 1'b1;
        is_prefix  = 1'b1;
      end
      OpRep: begin
        rep_seen  = 1'b1;
        is_prefix = 1'b1;
      end
      OpMovsB, OpMovsW: res.uses_source_index = 1'b1;
      OpStosB, OpStosW, OpLodsB, OpLodsW: ;
      OpCmpsB, OpCmpsW: begin
        res.writes_flags      = 1'b1;
        res.uses_source_index = 1'b1;
      end
      OpScasB, OpScasW: res.writes_flags = 1'b1;
      default: bad_byte = 1'b1;
    endcase
    if (is_prefix) begin
      if (!last && insn_bytes < MaxBytesDflt) begin
        return;
      end
    end else if (!bad_byte && rep_seen) begin
      res.accepted    = 1'b1;
      res.insn_length = insn_bytes;
      if (!code[0]) begin
        res.operand_size_code = SizeByte;
      end else if (rexw_seen) begin
        res.operand_size_code = SizeQword;
      end else if (opsize_seen) begin
        res.operand_size_code = SizeWord;
      end else begin
        res.operand_size_code = SizeDword;
      end
      res.repeat_not_equal = repne_seen;
      res.address_override = addrsize_seen;
    end
    if (!res.accepted) begin
      res = '0;
    end
    decoded_insns.insert(decoded_insns.size(), res);
    clear_insn_state();
    skipping = !last;
  endtask

  always @(posedge clk_i or negedge rst_ni) begin
    rsid_result_t got;
    rsid_result_t want;
    if (!rst_ni) begin
      decoded_insns.delete();
      long_mode         = 1'b1;
      mismatch_count_o  = 0;
      pending_o         = 0;
      decoded_bytes_o   = 0;
      results_checked_o = 0;
      insns_accepted_o  = 0;
      clear_insn_state();
    end else begin
      if (out_valid_i && !out_stall_i) begin
        got = '{accepted_i, insn_length_i, operand_size_code_i, writes_flags_i,
                uses_source_index_i, repeat_not_equal_i, address_override_i};
        results_checked_o++;
        if (got.accepted) begin
          insns_accepted_o++;
        end
        if (decoded_insns.size() == 0) begin
          if (mismatch_count_o < 10) begin
            $display("%0t: unexpected result acc=%0b len=%0d size=%0d flags=%0b si=%0b",
                     $realtime, got.accepted, got.insn_length, got.operand_size_code,
                     got.writes_flags, got.uses_source_index);
          end
          mismatch_count_o++;
        end else begin
          want = decoded_insns.pop_front();
          if (got.accepted !== want.accepted || got.insn_length !== want.insn_length ||
              got.operand_size_code !== want.operand_size_code ||
              got.writes_flags !== want.writes_flags ||
              got.uses_source_index !== want.uses_source_index ||
              got.repeat_not_equal !== want.repeat_not_equal ||
              got.address_override !== want.address_override) begin
            if (mismatch_count_o < 10) begin
              $display("%0t: result mismatch (acc len size flags si repne addr)", $realtime);
              $display("  expected %0b %0d %0d %0b %0b %0b %0b", want.accepted,
                       want.insn_length, want.operand_size_code, want.writes_flags,
                       want.uses_source_index, want.repeat_not_equal, want.address_override);
              $display("  actual   %0b %0d %0d %0b %0b %0b %0b", got.accepted,
                       got.insn_length, got.operand_size_code, got.writes_flags,
                       got.uses_source_index, got.repeat_not_equal, got.address_override);
            end
            mismatch_count_o++;
          end
        end
      end
      if (mode_64bit_we_i) begin
        long_mode = mode_64bit_i;
      end
      if (in_valid_i && !in_stall_i) begin
        decode_code_byte(code_byte_i, end_of_buffer_i);
      end
      pending_o = decoded_insns.size();
    end
  end

endmodule

// File: bench/rep_string_instruction_decoder_test.sv
module rep_string_instruction_decoder_test;
  timeunit 1ns;
  timeprecision 1ps;
  import rsid_pkg::*;

  localparam logic Eob = 1'b1;
  localparam logic Mid = 1'b0;
  localparam int   IdleLimit = 2000;

  localparam logic [8:0] LongModeSeq [24] = '{
    {Mid, OpRep}, {Eob, OpMovsB},
    {Mid, OpOperandSize}, {Mid, OpOperandSize}, {Mid, OpRep}, {Eob, OpMovsW},
    {Mid, OpRepne}, {Mid, OpAddrSize}, {Eob, OpCmpsB},
    {Mid, OpRexW}, {Mid, OpOperandSize}, {Mid, OpRep}, {Eob, OpScasW},
    {Mid, OpRep}, {Mid, OpStosW}, {Mid, 8'h00}, {Eob, 8'hFF},
    {Eob, OpScasB},
    {Eob, OpRep},
    {Eob, 8'h12},
    {Mid, OpRep}, {Mid, OpLodsW}, {Mid, OpStosB}, {Eob, 8'h55}
  };

  localparam logic [8:0] LegacyModeSeq [6] = '{
    {Mid, OpRep}, {Mid, OpRexW}, {Mid, OpMovsW}, {Eob, OpScasW},
    {Mid, OpRep}, {Eob, OpCmpsW}
  };

  localparam logic [7:0] PrefixSet [5] = '{
    OpOperandSize, OpAddrSize, OpRexW, OpRepne, OpRep
  };

  localparam logic [7:0] StringOps [10] = '{
    OpMovsB, OpMovsW, OpCmpsB, OpCmpsW, OpStosB,
    OpStosW, OpLodsB, OpLodsW, OpScasB, OpScasW
  };

  logic       clk_i = 1'b0;
  logic       rst_ni;
  logic       mode_64bit_we_i;
  logic       mode_64bit_i;
  logic       in_valid_i;
  logic       in_stall_o;
  logic [7:0] code_byte_i;
  logic       end_of_buffer_i;
  logic       out_valid_o;
  logic       out_stall_i;
  logic       accepted_o;
  logic [5:0] insn_length_o;
  logic [1:0] operand_size_code_o;
  logic       writes_flags_o;
  logic       uses_source_index_o;
  logic       repeat_not_equal_o;
  logic       address_override_o;

  int mismatches;
  int pending;
  int decoded_bytes;
  int results_checked;
  int insns_accepted;
  int sent_bytes = 0;
  int idle_cycles = 0;
  bit steady_feed = 1'b0;

  always begin
    #5 clk_i = 1'b1;
    #5 clk_i = 1'b0;
  end

  rep_string_instruction_decoder u_dut (
    .clk_i               (clk_i),
    .rst_ni              (rst_ni),
    .mode_64bit_we_i     (mode_64bit_we_i),
    .mode_64bit_i        (mode_64bit_i),
    .in_valid_i          (in_valid_i),
    .in_stall_o          (in_stall_o),
    .code_byte_i         (code_byte_i),
    .end_of_buffer_i     (end_of_buffer_i),
    .out_valid_o         (out_valid_o),
    .out_stall_i         (out_stall_i),
    .accepted_o          (accepted_o),
    .insn_length_o       (insn_length_o),
    .operand_size_code_o (operand_size_code_o),
    .writes_flags_o      (writes_flags_o),
    .uses_source_index_o (uses_source_index_o),
    .repeat_not_equal_o  (repeat_not_equal_o),
    .address_override_o  (address_override_o)
  );

  rep_string_decode_checker u_checker (
    .clk_i               (clk_i),
    .rst_ni              (rst_ni),
    .mode_64bit_we_i     (mode_64bit_we_i),
    .mode_64bit_i        (mode_64bit_i),
    .in_valid_i          (in_valid_i),
    .in_stall_i          (in_stall_o),
    .code_byte_i         (code_byte_i),
    .end_of_buffer_i     (end_of_buffer_i),
    .out_valid_i         (out_valid_o),
    .out_stall_i         (out_stall_i),
    .accepted_i          (accepted_o),
    .insn_length_i       (insn_length_o),
    .operand_size_code_i (operand_size_code_o),
    .writes_flags_i      (writes_flags_o),
    .uses_source_index_i (uses_source_index_o),
    .repeat_not_equal_i  (repeat_not_equal_o),
    .address_override_i  (address_override_o),
    .mismatch_count_o    (mismatches),
    .pending_o           (pending),
    .decoded_bytes_o     (decoded_bytes),
    .results_checked_o   (results_checked),
    .insns_accepted_o    (insns_accepted)
  );

  task automatic send_byte(input logic [7:0] code, input logic last);
    int gap;
    int pick;
    gap = 0;
    if (!steady_feed) begin
      pick = $urandom_range(0, 99);
      if (pick >= 92) begin
        gap = $urandom_range(10, 30);
      end else if (pick >= 70) begin
        gap = $urandom_range(1, 3);
      end
    end
    if (gap > 0) begin
      in_valid_i <= 1'b0;
      repeat (gap) @(negedge clk_i);
    end
    in_valid_i      <= 1'b1;
    code_byte_i     <= code;
    end_of_buffer_i <= last;
    do @(posedge clk_i); while (in_stall_o);
    @(negedge clk_i);
    sent_bytes++;
  endtask

  // hold input until all results are out and the decode stage has settled
  task automatic drain_decoder();
    in_valid_i <= 1'b0;
    while (pending != 0) @(negedge clk_i);
    repeat (4) @(negedge clk_i);
  endtask

  task automatic write_mode(input logic long_mode);
    drain_decoder();
    mode_64bit_we_i <= 1'b1;
    mode_64bit_i    <= long_mode;
    @(negedge clk_i);
    mode_64bit_we_i <= 1'b0;
  endtask

  initial begin
    int         hold_len;
    logic       hold;
    int         pick;
    out_stall_i = 1'b0;
    @(posedge rst_ni);
    forever begin
      pick = $urandom_range(0, 99);
      if (pick < 45) begin
        hold     = 1'b0;
        hold_len = $urandom_range(1, 20);
      end else if (pick < 55) begin
        hold     = 1'b0;
        hold_len = $urandom_range(100, 300);
      end else if (pick < 88) begin
        hold     = 1'b1;
        hold_len = $urandom_range(1, 3);
      end else begin
        hold     = 1'b1;
        hold_len = $urandom_range(10, 40);
      end
      out_stall_i <= hold;
      repeat (hold_len) @(negedge clk_i);
    end
  end

  always @(posedge clk_i) begin
    if (rst_ni) begin
      if ((in_valid_i && !in_stall_o) || (out_valid_o && !out_stall_i) || mode_64bit_we_i) begin
        idle_cycles <= 0;
      end else if (idle_cycles + 1 >= IdleLimit) begin
        $display("Timeout: no transaction for %0d cycles", IdleLimit);
        $display("Verification failed");
        $finish;
      end else begin
        idle_cycles <= idle_cycles + 1;
      end
    end
  end

  initial begin
    int         n_pfx;
    int         rep_at;
    int         n_tail;
    int         n_noise;
    int         kind;
    int         next_mode_switch;
    logic       cut;
    logic       last;
    logic [7:0] code;
    rst_ni          = 1'b0;
    in_valid_i      = 1'b0;
    code_byte_i     = '0;
    end_of_buffer_i = 1'b0;
    mode_64bit_we_i = 1'b0;
    mode_64bit_i    = 1'b0;
    repeat (4) @(negedge clk_i);
    rst_ni <= 1'b1;
    @(negedge clk_i);

    foreach (LongModeSeq[i]) send_byte(LongModeSeq[i][7:0], LongModeSeq[i][8]);
    write_mode(1'b0);
    foreach (LegacyModeSeq[i]) send_byte(LegacyModeSeq[i][7:0], LegacyModeSeq[i][8]);
    write_mode(1'b1);

    next_mode_switch = decoded_bytes + 150;
    while (sent_bytes < 1000) begin
      if (decoded_bytes >= next_mode_switch) begin
        write_mode(1'($urandom_range(0, 1)));
        next_mode_switch += 150;
      end
      if ($urandom_range(0, 19) == 0) begin
        steady_feed = !steady_feed;
      end
      kind = $urandom_range(0, 99);
      if (kind < 70) begin
        n_pfx  = ($urandom_range(0, 14) == 0) ? $urandom_range(28, 33) : $urandom_range(0, 4);
        rep_at = (n_pfx > 0 && $urandom_range(0, 9) != 0) ? $urandom_range(0, n_pfx - 1) : -1;
        cut    = 1'b0;
        for (int i = 0; i < n_pfx && !cut; i++) begin
          if (i == rep_at) begin
            code = $urandom_range(0, 1) ? OpRep : OpRepne;
          end else begin
            code = PrefixSet[$urandom_range(0, 4)];
          end
          cut = ($urandom_range(0, 39) == 0);
          send_byte(code, cut);
        end
        if (!cut) begin
          last = 1'($urandom_range(0, 1));
          send_byte(StringOps[$urandom_range(0, 9)], last);
          if (!last) begin
            n_tail = $urandom_range(0, 3);
            repeat (n_tail) send_byte(8'($urandom_range(0, 255)), 1'b0);
            send_byte(8'($urandom_range(0, 255)), 1'b1);
          end
        end
      end else if (kind < 85) begin
        n_noise = $urandom_range(1, 5);
        for (int i = 0; i < n_noise; i++) begin
          send_byte(8'($urandom_range(0, 255)),
                    (i == n_noise - 1) || ($urandom_range(0, 3) == 0));
        end
      end else begin
        repeat ($urandom_range(0, 3)) send_byte(PrefixSet[$urandom_range(0, 4)], 1'b0);
        if ($urandom_range(0, 1)) begin
          send_byte(PrefixSet[$urandom_range(0, 4)], 1'b1);
        end else begin
          send_byte(8'($urandom_range(0, 255)), 1'($urandom_range(0, 1)));
        end
      end
    end

    drain_decoder();
    repeat (10) @(negedge clk_i);
    $display("Sent %0d code bytes, %0d of them decoded, in 64-bit and legacy mode",
             sent_bytes, decoded_bytes);
    $display("Checked %0d results, %0d accepted REP string instructions",
             results_checked, insns_accepted);
    if (mismatches == 0 && pending == 0) begin
      $display("Verification passed");
    end else begin
      $display("Verification failed");
    end
    $finish;
  end

endmodule
